// ===== rtl/lpm_pkg.sv =====
// package for the longest prefix match routing table
// request, response and route entry types, status and mode codes, prefix helpers
// no dependencies
package lpm_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 16;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [5:0]  MAX_PREFIX = 6'd32;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FORWARDED = 3'd4;
  localparam logic [2:0] ST_DROPPED   = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] net_addr;
    logic [5:0]  prefix_len;
    logic [31:0] gateway_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] gateway_out;
    logic [5:0]  match_len;
  } rsp_t;

  typedef struct packed {
    logic [31:0] network;
    logic [5:0]  length;
    logic [31:0] gateway;
  } entry_t;

  // compare results for one entry against the pending request
  typedef struct packed {
    logic del_hit;
    logic route_hit;
    logic take;
  } match_t;

  function automatic logic [5:0] clamp_len(input logic [5:0] len);
    clamp_len = (len > MAX_PREFIX) ? MAX_PREFIX : len;
  endfunction

  // len is 0..32; a shift by 32 clears the word
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    len_mask = ~(ALL_ONES >> len);
  endfunction

endpackage

// ===== rtl/lpm_route_mem.sv =====
// route storage: one write port, one read port with registered read data
// depends on lpm_pkg for the entry type
module lpm_route_mem #(
  parameter int unsigned DEPTH = lpm_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  lpm_pkg::entry_t     wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output lpm_pkg::entry_t     rd_data
);

  lpm_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lpm_match_unit.sv =====
// shared compare unit: checks one stored route against the pending request
// depends on lpm_pkg for request, entry and match types
module lpm_match_unit (
  input  lpm_pkg::req_t   req,
  input  lpm_pkg::entry_t ent,
  input  logic            found,
  input  logic [5:0]      best_len,
  output lpm_pkg::match_t m
);

  always_comb begin
    m.del_hit   = (ent.network == req.net_addr) && (ent.length == req.prefix_len);
    // request address is already masked by its own prefix
    m.route_hit = (req.net_addr & lpm_pkg::len_mask(ent.length)) == ent.network;
    // strictly longer wins so the earliest route keeps a tie
    m.take      = m.route_hit && (!found || (ent.length > best_len));
  end

endmodule

// ===== rtl/longest_prefix_match_table.sv =====
// Routing table of TABLE_DEPTH IPv4 routes kept in insertion order, one word in and one
// word out per request. An add or a request with the unused mode code goes straight to the
// done state; a delete or a lookup first scans the stored routes through the single read
// port of the route memory, one route a cycle, then goes to the done state. The done state
// loads the answer into the output register once it is free. Delete compacts the table in
// the same pass, writing each kept route back at its new place. A new word is taken only
// while no request is in progress; a finished answer sits in the output register until taken.
// depends on lpm_pkg, lpm_route_mem, lpm_match_unit
module longest_prefix_match_table #(
  parameter int unsigned TABLE_DEPTH = lpm_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lpm_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lpm_pkg::rsp_t out_data
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t           state;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] kept;
  logic             pend;
  lpm_pkg::req_t    req;
  logic             found;
  logic [5:0]       best_len;
  logic [31:0]      best_gw;
  lpm_pkg::rsp_t    res;

  logic             in_fire;
  logic [5:0]       in_len;
  logic [31:0]      in_masked;
  logic             table_full;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  lpm_pkg::entry_t  wr_data;
  lpm_pkg::entry_t  rd_data;
  lpm_pkg::match_t  m;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_len     = lpm_pkg::clamp_len(in_data.prefix_len);
  assign in_masked  = in_data.net_addr & lpm_pkg::len_mask(in_len);
  assign table_full = (entry_count == FULL_COUNT);
  assign rd_en      = (state == S_SCAN) && (scan_idx < entry_count);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = entry_count[IDX_W-1:0];
    wr_data = '{network: in_masked, length: in_len, gateway: in_data.gateway_addr};
    if (in_fire && (in_data.mode == lpm_pkg::MODE_ADD) && !table_full) begin
      wr_en = 1'b1;
    end else if ((state == S_SCAN) && pend && (req.mode == lpm_pkg::MODE_DELETE)
                 && !m.del_hit) begin
      // compaction: kept never passes the read pointer
      wr_en   = 1'b1;
      wr_addr = kept[IDX_W-1:0];
      wr_data = rd_data;
    end
  end

  lpm_route_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  lpm_match_unit u_match (
    .req      (req),
    .ent      (rd_data),
    .found    (found),
    .best_len (best_len),
    .m        (m)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      scan_idx    <= '0;
      kept        <= '0;
      pend        <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            req      <= '{mode: in_data.mode, net_addr: in_masked, prefix_len: in_len,
                          gateway_addr: in_data.gateway_addr};
            scan_idx <= '0;
            kept     <= '0;
            pend     <= 1'b0;
            found    <= 1'b0;
            best_len <= '0;
            best_gw  <= '0;
            case (in_data.mode)
              lpm_pkg::MODE_ADD: begin
                state <= S_DONE;
                res   <= '{status: table_full ? lpm_pkg::ST_FULL : lpm_pkg::ST_ADDED,
                           gateway_out: '0, match_len: '0};
                if (!table_full) begin
                  entry_count <= entry_count + 1'b1;
                end
              end
              lpm_pkg::MODE_DELETE, lpm_pkg::MODE_LOOKUP: begin
                state <= S_SCAN;
                res   <= '{status: lpm_pkg::ST_DROPPED, gateway_out: '0, match_len: '0};
              end
              default: begin
                state <= S_DONE;
                res   <= '{status: lpm_pkg::ST_DROPPED, gateway_out: '0, match_len: '0};
              end
            endcase
          end
        end
        S_SCAN: begin
          pend <= rd_en;
          if (rd_en) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (pend) begin
            if (req.mode == lpm_pkg::MODE_DELETE) begin
              if (!m.del_hit) begin
                kept <= kept + 1'b1;
              end
            end else if (m.take) begin
              found    <= 1'b1;
              best_len <= rd_data.length;
              best_gw  <= rd_data.gateway;
            end
          end
          if (!rd_en && !pend) begin
            state <= S_DONE;
            if (req.mode == lpm_pkg::MODE_DELETE) begin
              entry_count <= kept;
              res.status  <= (kept != entry_count) ? lpm_pkg::ST_REMOVED
                                                   : lpm_pkg::ST_NOT_FOUND;
            end else if (found) begin
              res <= '{status: lpm_pkg::ST_FORWARDED, gateway_out: best_gw,
                       match_len: best_len};
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_COUNT)
    else $error("route count above table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= entry_count) && (kept <= scan_idx))
    else $error("scan pointers out of order");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !pend)
    else $error("read data still pending after scan");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != lpm_pkg::ST_FORWARDED))
      |-> (out_data.gateway_out == '0) && (out_data.match_len == '0))
    else $error("nonzero route fields without forwarding");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_data.mode == lpm_pkg::MODE_ADD) && !table_full)
      |=> (entry_count == $past(entry_count) + 1'b1))
    else $error("add did not grow the table");

endmodule

// ===== dv/tb_longest_prefix_match_table.sv =====
// testbench for longest_prefix_match_table: directed and random add, delete and lookup words
// checked against an in-bench route table predictor, with random idling on both channels
// depends on lpm_pkg and the rtl of longest_prefix_match_table
`timescale 1ns / 1ps

module tb_longest_prefix_match_table;

  localparam int DEPTH = 16;
  localparam int RANDOM_WORDS = 1250;
  localparam int PHASE_WORDS = 125;
  // mode code with no request kind behind it
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    lpm_pkg::req_t req;
    bit            drain_first;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  lpm_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lpm_pkg::rsp_t out_data;

  longest_prefix_match_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  pending_t      req_pending[$];
  lpm_pkg::rsp_t rsp_expected[$];
  logic          in_fire = 1'b0;
  int            errors = 0;
  int            words_sent = 0;
  int            rsp_seen = 0;

  // predicted route table
  logic [31:0] tbl_net[DEPTH];
  logic [5:0]  tbl_len[DEPTH];
  logic [31:0] tbl_gw[DEPTH];
  int          tbl_count = 0;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    if (len == 6'd0) return 32'd0;
    return lpm_pkg::ALL_ONES << (6'd32 - len);
  endfunction

  function automatic lpm_pkg::rsp_t route_predict(input lpm_pkg::req_t r);
    lpm_pkg::rsp_t res;
    logic [5:0]    len;
    logic [31:0]   masked;
    int            kept;
    bit            found;
    len = (r.prefix_len > lpm_pkg::MAX_PREFIX) ? lpm_pkg::MAX_PREFIX : r.prefix_len;
    masked = r.net_addr & prefix_mask(len);
    res = '0;
    res.status = lpm_pkg::ST_DROPPED;
    found = 0;
    kept = 0;
    case (r.mode)
      lpm_pkg::MODE_ADD: begin
        if (tbl_count >= DEPTH) begin
          res.status = lpm_pkg::ST_FULL;
        end else begin
          tbl_net[tbl_count] = masked;
          tbl_len[tbl_count] = len;
          tbl_gw[tbl_count] = r.gateway_addr;
          tbl_count++;
          res.status = lpm_pkg::ST_ADDED;
        end
      end
      lpm_pkg::MODE_DELETE: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (!(tbl_net[i] == masked && tbl_len[i] == len)) begin
            tbl_net[kept] = tbl_net[i];
            tbl_len[kept] = tbl_len[i];
            tbl_gw[kept] = tbl_gw[i];
            kept++;
          end
        end
        res.status = (kept != tbl_count) ? lpm_pkg::ST_REMOVED : lpm_pkg::ST_NOT_FOUND;
        tbl_count = kept;
      end
      lpm_pkg::MODE_LOOKUP: begin
        for (int i = 0; i < tbl_count; i++) begin
          if ((masked & prefix_mask(tbl_len[i])) == tbl_net[i] &&
              (!found || tbl_len[i] > res.match_len)) begin
            found = 1;
            res.match_len = tbl_len[i];
            res.gateway_out = tbl_gw[i];
          end
        end
        if (found) res.status = lpm_pkg::ST_FORWARDED;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic queue_req(input logic [1:0] mode, input logic [31:0] addr,
                           input logic [5:0] len, input logic [31:0] gw,
                           input bit drain_first);
    pending_t p;
    p.req.mode = mode;
    p.req.net_addr = addr;
    p.req.prefix_len = len;
    p.req.gateway_addr = gw;
    p.drain_first = drain_first;
    req_pending.insert(req_pending.size(), p);
  endtask

  function automatic int draw_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // input and output monitor: predict on accept, check on response
  always @(posedge clk) begin : monitor
    lpm_pkg::rsp_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready)
        rsp_expected.insert(rsp_expected.size(), route_predict(in_data));
      if (out_valid && out_ready) begin
        rsp_seen++;
        if (rsp_expected.size() == 0) begin
          report_mismatch("unexpected word status", 32'(out_data.status), 32'd0);
        end else begin
          want = rsp_expected.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.gateway_out !== want.gateway_out)
            report_mismatch("gateway_out", out_data.gateway_out, want.gateway_out);
          if (out_data.match_len !== want.match_len)
            report_mismatch("match_len", 32'(out_data.match_len), 32'(want.match_len));
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin : driver
    int gap_left;
    if (!rst && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_pending.size() > 0 &&
                   !(req_pending[0].drain_first && rsp_expected.size() != 0)) begin
        in_data <= req_pending[0].req;
        in_valid <= 1'b1;
        req_pending.delete(0);
        words_sent++;
        gap_left = draw_gap(((words_sent / 97) % 4) == 0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // response sink, with one long hold-off so the block backs up
  always @(negedge clk) begin : sink
    int stall_left;
    int hold_left;
    bit hold_done;
    int r;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && rsp_seen >= 200) begin
      hold_done = 1;
      hold_left = 150;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (((rsp_seen / 89) % 4) == 1) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
        out_ready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] pool_net[6];
    logic [5:0]  pool_len[6];
    logic [31:0] host;
    logic [5:0]  len;
    logic [1:0]  mode;
    int          k;
    int          r;
    int          add_pct;
    int          del_pct;

    // directed: empty table, /0 and /32 routes, saturated prefix, ties, mode 3
    queue_req(lpm_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd32, 32'h0, 0);
    queue_req(lpm_pkg::MODE_DELETE, 32'h0A01_0000, 6'd16, 32'h0, 0);
    queue_req(lpm_pkg::MODE_ADD, 32'hFFFF_FFFF, 6'd0, 32'h1111_1111, 0);
    queue_req(lpm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 0);
    queue_req(lpm_pkg::MODE_ADD, 32'h0A01_0203, 6'd63, 32'h2222_2222, 0);
    queue_req(lpm_pkg::MODE_ADD, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 0);
    queue_req(lpm_pkg::MODE_ADD, 32'h0A01_0203, 6'd16, 32'h4444_4444, 0);
    queue_req(lpm_pkg::MODE_ADD, 32'h0A01_FFFF, 6'd16, 32'h5555_5555, 0);
    queue_req(lpm_pkg::MODE_LOOKUP, 32'h0A01_0203, 6'd32, 32'h0, 0);
    queue_req(lpm_pkg::MODE_LOOKUP, 32'h0A01_0909, 6'd32, 32'h0, 0);
    queue_req(lpm_pkg::MODE_LOOKUP, 32'h0A01_0203, 6'd16, 32'h0, 0);
    queue_req(lpm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 6'd40, 32'h0, 0);
    queue_req(MODE_SPARE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 0);
    queue_req(lpm_pkg::MODE_DELETE, 32'h0A01_0707, 6'd16, 32'h0, 0);
    queue_req(lpm_pkg::MODE_LOOKUP, 32'h0A01_0909, 6'd32, 32'h0, 0);
    queue_req(lpm_pkg::MODE_DELETE, 32'h0A01_0203, 6'd33, 32'h0, 0);
    queue_req(lpm_pkg::MODE_DELETE, 32'h1234_5678, 6'd0, 32'h0, 0);
    queue_req(lpm_pkg::MODE_DELETE, 32'h0000_0000, 6'd0, 32'h0, 0);
    queue_req(lpm_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 0);
    queue_req(lpm_pkg::MODE_ADD, 32'h0000_0000, 6'd32, 32'h0000_0000, 0);
    queue_req(lpm_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd32, 32'h0, 0);
    queue_req(lpm_pkg::MODE_DELETE, 32'hFFFF_FFFF, 6'd32, 32'h0, 0);
    queue_req(lpm_pkg::MODE_DELETE, 32'h0000_0000, 6'd32, 32'h0, 0);

    // random: phases cycle through fill, mixed and drain, each on a fresh route pool
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_WORDS == 0) begin
        for (int p = 0; p < 6; p++) begin
          r = $urandom_range(0, 9);
          pool_len[p] = (r == 0) ? 6'd0 : (r < 3) ? 6'd32 : 6'($urandom_range(1, 31));
          pool_net[p] = $urandom() & prefix_mask(pool_len[p]);
        end
        case ((n / PHASE_WORDS) % 3)
          0: begin add_pct = 70; del_pct = 5; end
          1: begin add_pct = 35; del_pct = 20; end
          default: begin add_pct = 15; del_pct = 40; end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < add_pct) mode = lpm_pkg::MODE_ADD;
      else if (r < add_pct + del_pct) mode = lpm_pkg::MODE_DELETE;
      else if (r < 97) mode = lpm_pkg::MODE_LOOKUP;
      else mode = MODE_SPARE;
      k = $urandom_range(0, 5);
      host = $urandom();
      if ($urandom_range(0, 4) == 0) begin
        // noise: unrelated address and any 6-bit prefix
        len = 6'($urandom_range(0, 63));
        queue_req(mode, host, len, $urandom(), n % PHASE_WORDS == 0);
      end else begin
        len = pool_len[k];
        if (mode == lpm_pkg::MODE_LOOKUP && $urandom_range(0, 2) != 0) len = 6'd32;
        // any prefix above 32 acts as /32
        if (len == 6'd32 && $urandom_range(0, 1)) len = 6'($urandom_range(33, 63));
        queue_req(mode, pool_net[k] | (host & ~prefix_mask(pool_len[k])), len,
                  $urandom(), n % PHASE_WORDS == 0);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_pending.size() != 0 || in_valid || rsp_expected.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && rsp_expected.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
